>>> rtl/imu_offset_auto_calibrator_defines.svh
// assertion macros for the imu offset calibrator
`ifndef IMU_OFFSET_AUTO_CALIBRATOR_DEFINES_SVH
`define IMU_OFFSET_AUTO_CALIBRATOR_DEFINES_SVH

// same-cycle implication
`define IMUOAC_ASSERT_NOW(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define IMUOAC_ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/imuoac_pkg.sv
// shared constants and helpers for the imu offset calibrator
package imuoac_pkg;
    localparam int AXES       = 6;
    localparam int SUM_WIDTH  = 33;
    localparam int IDX_WIDTH  = 17;
    localparam int AXIS_WIDTH = 3;
    localparam int STEP_WIDTH = 6;

    localparam logic signed [17:0] ONE_G = 18'sd16384;

    localparam logic [7:0] REG_WINDOW_LENGTH = 8'd0;
    localparam logic [7:0] REG_SETTLE_COUNT  = 8'd1;
    localparam logic [7:0] REG_ACCEL_DZ      = 8'd2;
    localparam logic [7:0] REG_GYRO_DZ       = 8'd3;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEED   = 2'd1;
    localparam logic [1:0] PH_REFINE = 2'd2;
    localparam logic [1:0] PH_FINAL  = 2'd3;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction
endpackage

>>> rtl/imu_offset_auto_calibrator.sv
// imu offset calibrator top level
//
// Usage: one six-axis raw sample enters on the input channel (in_valid,
// in_stall) and exactly one result leaves on the output channel
// (out_valid, out_stall) carrying the six offsets, the phase and the
// offsets_written and calibration_done flags after that item.
// An item in idle phase is answered straight from the idle state;
// an item inside a window steps through the six axes, one 33-bit
// accumulate per axis, before its result shows. An item that closes
// a window runs, per axis, a bit-serial 33-step divide of its sum by
// the window length and, when refining an axis outside its deadzone,
// a second 33-step divide by the deadzone divisor, all through one
// shared shift-register divider. One item is worked on at a time; the
// next is taken when its result is taken or at the same edge.
// Reset sets the registers to their defaults, clears sums, offsets,
// phase and window position; no clearing pass is needed.
// While the receiver stalls, the result holds and in_stall stays high.
// Configuration is written through cfg_we, cfg_index, cfg_data while idle.
module imu_offset_auto_calibrator
    import imuoac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] offset_accel_x,
    output logic signed [15:0] offset_accel_y,
    output logic signed [15:0] offset_accel_z,
    output logic signed [15:0] offset_gyro_x,
    output logic signed [15:0] offset_gyro_y,
    output logic signed [15:0] offset_gyro_z,
    output logic [1:0]         phase,
    output logic               offsets_written,
    output logic               calibration_done
);

`include "imu_offset_auto_calibrator_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MEAN = 3'd3;
    localparam logic [2:0] S_CORR = 3'd4;
    localparam logic [2:0] S_QUOT = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_NEXT = 3'd7;

    localparam logic [AXIS_WIDTH-1:0] LAST_AXIS = AXIS_WIDTH'(AXES - 1);
    localparam logic [AXIS_WIDTH-1:0] AZ_AXIS   = AXIS_WIDTH'(2);
    localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(SUM_WIDTH - 1);

    logic [15:0] wl_reg;
    logic [7:0]  settle_reg;
    logic [7:0]  adz_reg;
    logic [7:0]  gdz_reg;

    logic [2:0]                 state_reg;
    logic [1:0]                 phase_reg;
    logic                       out_valid_reg;
    logic                       written_reg;
    logic                       done_reg;
    logic [IDX_WIDTH-1:0]       idx_reg;
    logic [IDX_WIDTH-1:0]       idx_w_reg;
    logic [AXIS_WIDTH-1:0]      axis_reg;
    logic [2:0]                 ready_reg;
    logic                       e_neg_reg;
    logic [STEP_WIDTH-1:0]      step_reg;
    logic [15:0]                rem_reg;
    logic [SUM_WIDTH-1:0]       dq_reg;
    logic [15:0]                dvsr_reg;
    logic signed [15:0]         samp_reg [AXES];
    logic [SUM_WIDTH-1:0]       sum_reg  [AXES];
    logic signed [15:0]         off_reg  [AXES];

    logic                  accept;
    logic [IDX_WIDTH-1:0]  lim;
    logic                  in_win;
    logic [SUM_WIDTH-1:0]  cur_sum;
    logic                  sum_neg;
    logic [SUM_WIDTH-1:0]  sum_mag;
    logic [16:0]           rem_sh;
    logic                  div_ge;
    logic [16:0]           rem_sub;
    logic [SUM_WIDTH-1:0]  q_signed;
    logic signed [15:0]    mean;
    logic signed [17:0]    mean_x;
    logic signed [17:0]    seed_v;
    logic [17:0]           seed_mag;
    logic [17:0]           seed_sh;
    logic signed [17:0]    seed_off;
    logic signed [17:0]    err;
    logic [17:0]           err_mag;
    logic                  is_accel;
    logic [7:0]            dz;
    logic                  axis_ready;
    logic [15:0]           corr_dvsr;
    logic signed [17:0]    qe;
    logic signed [17:0]    upd_v;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);

    assign lim    = IDX_WIDTH'({1'b0, wl_reg}) + IDX_WIDTH'(settle_reg);
    assign in_win = (idx_w_reg >= IDX_WIDTH'(settle_reg)) && (idx_w_reg < lim);

    assign cur_sum = sum_reg[axis_reg];
    assign sum_neg = cur_sum[SUM_WIDTH-1];
    assign sum_mag = sum_neg ? (~cur_sum + 1'b1) : cur_sum;

    // one restoring divide step
    assign rem_sh  = {rem_reg, dq_reg[SUM_WIDTH-1]};
    assign div_ge  = rem_sh >= {1'b0, dvsr_reg};
    assign rem_sub = rem_sh - {1'b0, dvsr_reg};

    assign q_signed = sum_neg ? (~dq_reg + 1'b1) : dq_reg;
    assign mean     = (wl_reg == 16'd0) ? 16'sd0 : $signed(q_signed[15:0]);
    assign mean_x   = 18'(mean);

    assign is_accel = axis_reg <= AZ_AXIS;

    // seeding: -mean/8 or (1g-mean)/8 for accel, -mean/4 for gyro
    assign seed_v   = (axis_reg == AZ_AXIS) ? (ONE_G - mean_x) : -mean_x;
    assign seed_mag = seed_v[17] ? 18'(-seed_v) : 18'(seed_v);
    assign seed_sh  = is_accel ? (seed_mag >> 3) : (seed_mag >> 2);
    assign seed_off = seed_v[17] ? -$signed(seed_sh) : $signed(seed_sh);

    // refining
    assign err        = (axis_reg == AZ_AXIS) ? (ONE_G - mean_x) : mean_x;
    assign err_mag    = err[17] ? 18'(-err) : 18'(err);
    assign dz         = is_accel ? adz_reg : gdz_reg;
    assign axis_ready = err_mag <= {10'd0, dz};
    assign corr_dvsr  = is_accel ? ((adz_reg == 8'd0) ? 16'd1 : {8'd0, adz_reg})
                                 : (16'({8'd0, gdz_reg}) + 16'd1);

    assign qe    = e_neg_reg ? -$signed(dq_reg[17:0]) : $signed(dq_reg[17:0]);
    assign upd_v = (axis_reg == AZ_AXIS) ? (18'(off_reg[axis_reg]) + qe)
                                         : (18'(off_reg[axis_reg]) - qe);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= 16'd1000;
            settle_reg    <= 8'd100;
            adz_reg       <= 8'd8;
            gdz_reg       <= 8'd1;
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            written_reg   <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            idx_w_reg     <= '0;
            axis_reg      <= '0;
            ready_reg     <= '0;
            step_reg      <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: wl_reg     <= cfg_data;
                    REG_SETTLE_COUNT:  settle_reg <= cfg_data[7:0];
                    REG_ACCEL_DZ:      adz_reg    <= cfg_data[7:0];
                    REG_GYRO_DZ:       gdz_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        samp_reg[0] <= accel_x;
                        samp_reg[1] <= accel_y;
                        samp_reg[2] <= accel_z;
                        samp_reg[3] <= gyro_x;
                        samp_reg[4] <= gyro_y;
                        samp_reg[5] <= gyro_z;
                        done_reg    <= 1'b0;
                        axis_reg    <= '0;
                        ready_reg   <= '0;
                        idx_w_reg   <= idx_reg;
                        if (phase_reg == PH_IDLE)
                        begin
                            for (int i = 0; i < AXES; i++)
                                off_reg[i] <= '0;
                            written_reg   <= 1'b1;
                            phase_reg     <= PH_SEED;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            written_reg <= 1'b0;
                            state_reg   <= (idx_reg == lim) ? S_DIV : S_ACC;
                        end
                    end
                end
                S_ACC:
                begin
                    if (in_win)
                        sum_reg[axis_reg] <= cur_sum + SUM_WIDTH'(samp_reg[axis_reg]);
                    if (axis_reg == LAST_AXIS)
                    begin
                        idx_reg       <= idx_w_reg + 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        axis_reg <= axis_reg + 1'b1;
                end
                S_DIV:
                begin
                    dq_reg    <= sum_mag;
                    rem_reg   <= '0;
                    dvsr_reg  <= wl_reg;
                    step_reg  <= '0;
                    state_reg <= S_MEAN;
                end
                S_MEAN, S_QUOT:
                begin
                    rem_reg  <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
                    dq_reg   <= {dq_reg[SUM_WIDTH-2:0], div_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= (state_reg == S_MEAN) ? S_CORR : S_UPD;
                end
                S_CORR:
                begin
                    sum_reg[axis_reg] <= '0;
                    state_reg         <= S_NEXT;
                    if (phase_reg == PH_SEED)
                        off_reg[axis_reg] <= sat16(seed_off);
                    else if (phase_reg == PH_REFINE)
                    begin
                        if (axis_ready)
                            ready_reg <= ready_reg + 1'b1;
                        else
                        begin
                            e_neg_reg <= err[17];
                            dq_reg    <= SUM_WIDTH'(err_mag);
                            rem_reg   <= '0;
                            dvsr_reg  <= corr_dvsr;
                            step_reg  <= '0;
                            state_reg <= S_QUOT;
                        end
                    end
                end
                S_UPD:
                begin
                    off_reg[axis_reg] <= sat16(upd_v);
                    state_reg         <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (axis_reg == LAST_AXIS)
                    begin
                        case (phase_reg)
                            PH_SEED:
                            begin
                                written_reg <= 1'b1;
                                phase_reg   <= PH_REFINE;
                            end
                            PH_REFINE:
                            begin
                                written_reg <= 1'b1;
                                if (ready_reg == 3'(AXES))
                                    phase_reg <= PH_FINAL;
                            end
                            default:
                            begin
                                done_reg  <= 1'b1;
                                phase_reg <= PH_IDLE;
                            end
                        endcase
                        idx_w_reg <= '0;
                        axis_reg  <= '0;
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_DIV;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign offset_accel_x   = off_reg[0];
    assign offset_accel_y   = off_reg[1];
    assign offset_accel_z   = off_reg[2];
    assign offset_gyro_x    = off_reg[3];
    assign offset_gyro_y    = off_reg[4];
    assign offset_gyro_z    = off_reg[5];
    assign phase            = phase_reg;
    assign offsets_written  = written_reg;
    assign calibration_done = done_reg;

    `IMUOAC_ASSERT_NOW(a_done_idle, out_valid && calibration_done, phase == PH_IDLE, "done outside idle phase")
    `IMUOAC_ASSERT_NOW(a_done_nowrite, out_valid && calibration_done, !offsets_written, "done with offsets written")
    `IMUOAC_ASSERT_NOW(a_busy_noout, state_reg != S_IDLE, !out_valid_reg, "result shown while busy")
    `IMUOAC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(phase), "stalled result changed")

endmodule

>>> test/imu_offset_auto_calibrator_checker.sv
// checker for the imu offset calibrator: follows the block state and compares every result
module imu_offset_auto_calibrator_checker
    import imuoac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] offset_accel_x,
    input  logic signed [15:0] offset_accel_y,
    input  logic signed [15:0] offset_accel_z,
    input  logic signed [15:0] offset_gyro_x,
    input  logic signed [15:0] offset_gyro_y,
    input  logic signed [15:0] offset_gyro_z,
    input  logic [1:0]         phase,
    input  logic               offsets_written,
    input  logic               calibration_done,
    output int                 errors,
    output int                 pending,
    output logic [1:0]         model_phase,
    output int                 done_count
);
    typedef struct packed {
        logic [5:0][15:0] offs;
        logic [1:0]       ph;
        logic             wr;
        logic             dn;
    } calib_result_t;

    calib_result_t    offset_queue[$];
    logic [15:0]      win_len;
    logic [7:0]       settle;
    logic [7:0]       acc_dz;
    logic [7:0]       gyr_dz;
    logic [1:0]       cur_phase;
    logic [16:0]      position;
    logic [32:0]      sums[6];
    logic [5:0][15:0] offs;

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint sx16(input logic [15:0] v);
        longint r;
        r = $signed(v);
        return r;
    endfunction

    task automatic advance_calibration(input logic [5:0][15:0] smp, output calib_result_t r);
        int          pos;
        int          lim;
        int          ready;
        longint      s;
        longint      q;
        longint      m[6];
        longint      adiv;
        longint      err;
        logic        wr;
        logic        dn;
        wr = 1'b0;
        dn = 1'b0;
        if (cur_phase == PH_IDLE)
        begin
            offs = '0;
            wr = 1'b1;
            cur_phase = PH_SEED;
        end
        else
        begin
            pos = position;
            lim = int'(settle) + int'(win_len);
            if (pos == lim)
            begin
                for (int a = 0; a < 6; a++)
                begin
                    s = $signed(sums[a]);
                    q = (win_len != 0) ? s / longint'(win_len) : 0;
                    m[a] = sx16(q[15:0]);
                    sums[a] = '0;
                end
                if (cur_phase == PH_SEED)
                begin
                    offs[0] = clip16(-m[0] / 8);
                    offs[1] = clip16(-m[1] / 8);
                    offs[2] = clip16((16384 - m[2]) / 8);
                    for (int a = 3; a < 6; a++)
                        offs[a] = clip16(-m[a] / 4);
                    wr = 1'b1;
                    cur_phase = PH_REFINE;
                end
                else if (cur_phase == PH_REFINE)
                begin
                    ready = 0;
                    adiv = (acc_dz != 0) ? longint'(acc_dz) : 1;
                    for (int a = 0; a < 2; a++)
                    begin
                        if ((m[a] < 0 ? -m[a] : m[a]) <= longint'(acc_dz))
                            ready++;
                        else
                            offs[a] = clip16(sx16(offs[a]) - m[a] / adiv);
                    end
                    err = 16384 - m[2];
                    if ((err < 0 ? -err : err) <= longint'(acc_dz))
                        ready++;
                    else
                        offs[2] = clip16(sx16(offs[2]) + err / adiv);
                    for (int a = 3; a < 6; a++)
                    begin
                        if ((m[a] < 0 ? -m[a] : m[a]) <= longint'(gyr_dz))
                            ready++;
                        else
                            offs[a] = clip16(sx16(offs[a]) - m[a] / (longint'(gyr_dz) + 1));
                    end
                    wr = 1'b1;
                    if (ready == 6)
                        cur_phase = PH_FINAL;
                end
                else
                begin
                    dn = 1'b1;
                    cur_phase = PH_IDLE;
                end
                pos = 0;
            end
            if (pos >= int'(settle) && pos < lim)
                for (int a = 0; a < 6; a++)
                    sums[a] = sums[a] + {{17{smp[a][15]}}, smp[a]};
            position = 17'(pos + 1);
        end
        r.offs = offs;
        r.ph = cur_phase;
        r.wr = wr;
        r.dn = dn;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        calib_result_t got;
        calib_result_t want;
        calib_result_t nxt;
        logic          bad;
        if (!rst_n)
        begin
            win_len = 16'd1000;
            settle = 8'd100;
            acc_dz = 8'd8;
            gyr_dz = 8'd1;
            cur_phase = PH_IDLE;
            position = '0;
            for (int a = 0; a < 6; a++)
                sums[a] = '0;
            offs = '0;
            offset_queue.delete();
            errors = 0;
            pending = 0;
            done_count = 0;
            model_phase = PH_IDLE;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.offs = {offset_gyro_z, offset_gyro_y, offset_gyro_x,
                            offset_accel_z, offset_accel_y, offset_accel_x};
                got.ph = phase;
                got.wr = offsets_written;
                got.dn = calibration_done;
                if (offset_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: got %h", got);
                end
                else
                begin
                    want = offset_queue.pop_front();
                    bad = (got.ph !== want.ph) || (got.wr !== want.wr) || (got.dn !== want.dn);
                    for (int a = 0; a < 6; a++)
                        if (got.offs[a] !== want.offs[a])
                            bad = 1'b1;
                    if (want.dn)
                        done_count++;
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected offs %h ph %0d wr %0d dn %0d, got offs %h ph %0d wr %0d dn %0d",
                                     want.offs, want.ph, want.wr, want.dn,
                                     got.offs, got.ph, got.wr, got.dn);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_calibration({gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x}, nxt);
                offset_queue.push_back(nxt);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: win_len = cfg_data;
                    REG_SETTLE_COUNT:  settle = cfg_data[7:0];
                    REG_ACCEL_DZ:      acc_dz = cfg_data[7:0];
                    REG_GYRO_DZ:       gyr_dz = cfg_data[7:0];
                    default: ;
                endcase
            end
            pending = offset_queue.size();
            model_phase = cur_phase;
        end
    end
endmodule

>>> test/tb_imu_offset_auto_calibrator.sv
// testbench top for the imu offset calibrator: stimulus, flow control and verdict
module tb_imu_offset_auto_calibrator;
    import imuoac_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [7:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] offset_accel_x, offset_accel_y, offset_accel_z;
    logic signed [15:0] offset_gyro_x, offset_gyro_y, offset_gyro_z;
    logic [1:0]         phase;
    logic               offsets_written;
    logic               calibration_done;
    int                 errors;
    int                 pending;
    logic [1:0]         model_phase;
    int                 done_count;

    int                 cycles;
    int                 items_sent;
    int                 settings_used;
    logic               calm;
    logic               long_hold;
    int                 cur_adz;
    int                 cur_gdz;
    int                 bias;

    imu_offset_auto_calibrator u_dut (.*);

    imu_offset_auto_calibrator_checker u_checker (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver side
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input int ax, input int ay, input int az,
                             input int gx, input int gy, input int gz);
        logic go;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        accel_x <= ax[15:0];
        accel_y <= ay[15:0];
        accel_z <= az[15:0];
        gyro_x <= gx[15:0];
        gyro_y <= gy[15:0];
        gyro_z <= gz[15:0];
        go = 1'b0;
        while (!go)
        begin
            #1;
            go = !in_stall;
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
        if (items_sent == 300)
            long_hold = 1'b1;
        if (items_sent == 600)
        begin
            in_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int wl, input int st, input int adz, input int gdz);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(negedge clk);
        write_reg(REG_WINDOW_LENGTH, wl[15:0]);
        write_reg(REG_SETTLE_COUNT, st[15:0]);
        write_reg(REG_ACCEL_DZ, adz[15:0]);
        write_reg(REG_GYRO_DZ, gdz[15:0]);
        cur_adz = adz;
        cur_gdz = gdz;
        settings_used++;
    endtask

    function automatic int jitter(input int j);
        return int'($urandom_range(0, 2 * j)) - j;
    endfunction

    // mostly samples that let the calibration converge, some biased, some raw noise
    task automatic send_session_item();
        int k;
        int ja;
        int jg;
        k = $urandom_range(0, 19);
        ja = (cur_adz > 40) ? 40 : cur_adz;
        jg = (cur_gdz > 40) ? 40 : cur_gdz;
        if (k < 14)
            send_item(jitter(ja), jitter(ja), 16384 + jitter(ja), jitter(jg), jitter(jg), jitter(jg));
        else if (k < 17)
            send_item(bias + jitter(ja), -bias, 16384 - bias, bias, -bias + jitter(jg), bias / 2);
        else
            send_item($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic run_session(input int wl, input int st, input int adz, input int gdz,
                               input int budget);
        set_config(wl, st, adz, gdz);
        bias = int'($urandom_range(0, 4000)) - 2000;
        for (int n = 0; n < budget; n++)
            send_session_item();
        // exact samples bring every axis inside its deadzone and finish the run
        while (model_phase != PH_IDLE)
            send_item(0, 0, 16384, 0, 0, 0);
    endtask

    initial
    begin
        int wl;
        int st;
        int adz;
        int gdz;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        gyro_x = '0;
        gyro_y = '0;
        gyro_z = '0;
        cycles = 0;
        items_sent = 0;
        settings_used = 0;
        calm = 1'b0;
        long_hold = 1'b0;
        cur_adz = 8;
        cur_gdz = 1;
        bias = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // start item under the reset settings
        send_item(32767, -32768, 16384, 0, -1, 1);

        // directed extremes
        set_config(2, 1, 255, 0);
        send_item(-32768, -32768, -32768, -32768, -32768, -32768);
        send_item(32767, 32767, 32767, 32767, 32767, 32767);
        send_item(32767, 32767, 32767, 32767, 32767, 32767);
        send_item(0, 0, 0, 0, 0, 0);
        send_item(-32768, -32768, -32768, -32768, -32768, -32768);
        send_item(-32768, -32768, -32768, -32768, -32768, -32768);
        send_item(-1, -1, 16384, -1, -1, -1);
        send_item(1, -1, 16383, 1, 0, -1);
        send_item(-1, 1, 16385, -1, 0, 1);
        send_item(-1, 1, 16385, -1, 0, 1);
        while (model_phase != PH_IDLE)
            send_item(0, 0, 16384, 0, 0, 0);

        // zero accel deadzone with settle zero, single-sample windows
        set_config(1, 0, 0, 255);
        send_item(0, 0, 16384, 255, -255, 100);
        send_item(1, -1, 16384, 256, -256, 0);
        send_item(-1, 1, 16384, 0, 0, 0);
        send_item(0, 0, 16384, 0, 0, 0);
        while (model_phase != PH_IDLE)
            send_item(0, 0, 16384, 0, 0, 0);

        while (items_sent < 1000)
        begin
            if (items_sent >= 900)
                calm = 1'b1;
            case ($urandom_range(0, 3))
                0: wl = 1;
                1: wl = $urandom_range(20, 60);
                default: wl = $urandom_range(2, 6);
            endcase
            st = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0: adz = 1;
                1: adz = 255;
                default: adz = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 2))
                0: gdz = 0;
                1: gdz = 255;
                default: gdz = $urandom_range(0, 20);
            endcase
            run_session(wl, st, adz, gdz, 1 + (wl + st) * $urandom_range(2, 6)
                        + $urandom_range(0, wl + st));
        end
        calm = 1'b1;

        // longest settle with the shortest window
        run_session(1, 255, 255, 255, 300);

        // zero window length: means are zero, so the run never converges
        set_config(0, 2, 255, 255);
        for (int n = 0; n < 30; n++)
            send_session_item();

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(negedge clk);
        $display("sent %0d samples over %0d register settings", items_sent, settings_used);
        $display("%0d calibrations ran to completion", done_count);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
